// ----- sv/pit_pkg.sv -----
// Package for the point-in-triangle test: coordinate and datapath widths,
// register codes and the structs that carry data between pipeline modules.
// No dependencies.
`default_nettype none

package pit_pkg;

  // Coordinate width of vertices and query points.
  localparam int CW  = 16;
  // Edge vector and point offset width (difference of two coordinates).
  localparam int DW  = CW + 1;
  // Width of one coordinate product.
  localparam int PW  = 2 * DW;
  // Width of a dot product (sum of three coordinate products).
  localparam int SW  = PW + 2;
  // Split of a dot product for the wide multiplies: unsigned low part, signed high part.
  localparam int LW  = (SW + 1) / 2;
  localparam int HW  = SW - LW;
  // Width of the product of two dot products.
  localparam int MW  = 2 * SW;
  // Width of the denominator and the two numerators.
  localparam int NW  = MW + 1;
  // Width of the numerator sum.
  localparam int UVW = NW + 1;

  // Stream and register port widths.
  localparam int IN_TDATA_W  = ((3 * CW + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_DW      = 64;
  localparam int CFG_AW      = 5;
  localparam int REG_IDX_W   = CFG_AW - 3;

  // Register indexes (byte address = 8 * index).
  localparam logic [REG_IDX_W-1:0] REG_VERTEX_A = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_VERTEX_B = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_VERTEX_C = 2'd2;

  // Triangle vertices, each three packed signed coordinates, x lowest.
  typedef struct packed {
    logic [3*CW-1:0] a;
    logic [3*CW-1:0] b;
    logic [3*CW-1:0] c;
  } verts_t;

  // The five dot products.
  typedef struct packed {
    logic signed [SW-1:0] d00;
    logic signed [SW-1:0] d01;
    logic signed [SW-1:0] d02;
    logic signed [SW-1:0] d11;
    logic signed [SW-1:0] d12;
  } dots_t;

  // Denominator and numerators of the barycentric coordinates.
  typedef struct packed {
    logic signed [NW-1:0] den;
    logic signed [NW-1:0] un;
    logic signed [NW-1:0] vn;
  } nums_t;

endpackage

`default_nettype wire

// ----- sv/pit_dot.sv -----
// Front of the pipeline: edge vectors and point offset, coordinate products,
// then the five dot products. Three register stages. Depends on pit_pkg.
`default_nettype none

module pit_dot
  import pit_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire verts_t          verts,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [3*CW-1:0] point,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output dots_t                dots
);

  logic [2:0] v_r;
  logic [2:0] en;

  logic signed [CW-1:0] ca [3];
  logic signed [CW-1:0] cb [3];
  logic signed [CW-1:0] cc [3];
  logic signed [CW-1:0] cp [3];

  logic signed [DW-1:0] e0_r [3];
  logic signed [DW-1:0] e1_r [3];
  logic signed [DW-1:0] w_r [3];
  logic signed [DW-1:0] e0_nxt [3];
  logic signed [DW-1:0] e1_nxt [3];
  logic signed [DW-1:0] w_nxt [3];

  // Products per dot product: 0 e0.e0, 1 e0.e1, 2 e0.w, 3 e1.e1, 4 e1.w.
  logic signed [PW-1:0] pr_r [5][3];
  logic signed [PW-1:0] pr_nxt [5][3];

  dots_t dots_r;
  dots_t dots_nxt;

  always_comb begin
    en[2] = !v_r[2] || out_ready;
    en[1] = !v_r[1] || en[2];
    en[0] = !v_r[0] || en[1];
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[2];
  assign dots      = dots_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ca[k] = verts.a[k*CW +: CW];
      cb[k] = verts.b[k*CW +: CW];
      cc[k] = verts.c[k*CW +: CW];
      cp[k] = point[k*CW +: CW];
      e0_nxt[k] = {cc[k][CW-1], cc[k]} - {ca[k][CW-1], ca[k]};
      e1_nxt[k] = {cb[k][CW-1], cb[k]} - {ca[k][CW-1], ca[k]};
      w_nxt[k]  = {cp[k][CW-1], cp[k]} - {ca[k][CW-1], ca[k]};
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pr_nxt[0][k] = e0_r[k] * e0_r[k];
      pr_nxt[1][k] = e0_r[k] * e1_r[k];
      pr_nxt[2][k] = e0_r[k] * w_r[k];
      pr_nxt[3][k] = e1_r[k] * e1_r[k];
      pr_nxt[4][k] = e1_r[k] * w_r[k];
    end
  end

  always_comb begin
    dots_nxt.d00 = pr_r[0][0] + pr_r[0][1] + pr_r[0][2];
    dots_nxt.d01 = pr_r[1][0] + pr_r[1][1] + pr_r[1][2];
    dots_nxt.d02 = pr_r[2][0] + pr_r[2][1] + pr_r[2][2];
    dots_nxt.d11 = pr_r[3][0] + pr_r[3][1] + pr_r[3][2];
    dots_nxt.d12 = pr_r[4][0] + pr_r[4][1] + pr_r[4][2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      e0_r <= e0_nxt;
      e1_r <= e1_nxt;
      w_r  <= w_nxt;
    end
    if (en[1]) begin
      pr_r <= pr_nxt;
    end
    if (en[2]) begin
      dots_r <= dots_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pit_cross.sv -----
// Middle of the pipeline: products of dot products split into two partial
// products each, their sums, then denominator and numerators. Depends on pit_pkg.
`default_nettype none

module pit_cross
  import pit_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire dots_t dots,
  output logic       out_valid,
  input  wire logic  out_ready,
  output nums_t      nums
);

  logic [2:0] v_r;
  logic [2:0] en;

  // Product pairs: 0 d00*d11, 1 d01*d01, 2 d11*d02, 3 d01*d12, 4 d00*d12, 5 d01*d02.
  logic signed [SW-1:0] xs [6];
  logic signed [SW-1:0] ys [6];

  logic signed [SW+LW:0]   lo_r [6];
  logic signed [SW+HW-1:0] hi_r [6];
  logic signed [SW+LW:0]   lo_nxt [6];
  logic signed [SW+HW-1:0] hi_nxt [6];

  logic signed [MW-1:0] hx [6];
  logic signed [MW-1:0] lx [6];
  logic signed [MW-1:0] prod_r [6];
  logic signed [MW-1:0] prod_nxt [6];

  nums_t nums_r;
  nums_t nums_nxt;

  always_comb begin
    en[2] = !v_r[2] || out_ready;
    en[1] = !v_r[1] || en[2];
    en[0] = !v_r[0] || en[1];
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[2];
  assign nums      = nums_r;

  always_comb begin
    xs[0] = dots.d00;  ys[0] = dots.d11;
    xs[1] = dots.d01;  ys[1] = dots.d01;
    xs[2] = dots.d11;  ys[2] = dots.d02;
    xs[3] = dots.d01;  ys[3] = dots.d12;
    xs[4] = dots.d00;  ys[4] = dots.d12;
    xs[5] = dots.d01;  ys[5] = dots.d02;
    for (int i = 0; i < 6; i++) begin
      // Low half taken as unsigned, high half keeps the sign.
      lo_nxt[i] = xs[i] * $signed({1'b0, ys[i][LW-1:0]});
      hi_nxt[i] = xs[i] * $signed(ys[i][SW-1:LW]);
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      hx[i] = hi_r[i];
      lx[i] = lo_r[i];
      prod_nxt[i] = (hx[i] <<< LW) + lx[i];
    end
  end

  always_comb begin
    nums_nxt.den = prod_r[0] - prod_r[1];
    nums_nxt.un  = prod_r[2] - prod_r[3];
    nums_nxt.vn  = prod_r[4] - prod_r[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    if (en[1]) begin
      prod_r <= prod_nxt;
    end
    if (en[2]) begin
      nums_r <= nums_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pit_decide.sv -----
// Back of the pipeline: numerator sum and sign flags, then the sign-corrected
// inside test and the degenerate flag in the output register. Depends on pit_pkg.
`default_nettype none

module pit_decide
  import pit_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire nums_t nums,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic       inside_res,
  output logic       degenerate
);

  logic [1:0] v_r;
  logic [1:0] en;

  logic signed [UVW-1:0] uv_r, uv_nxt;
  logic signed [NW-1:0]  den_r;
  logic dzero_r, dneg_r, uneg_r, uzero_r, vneg_r, vzero_r;

  logic inside_r, inside_nxt;
  logic degen_r;

  always_comb begin
    en[1] = !v_r[1] || out_ready;
    en[0] = !v_r[0] || en[1];
  end

  assign in_ready   = en[0];
  assign out_valid  = v_r[1];
  assign inside_res = inside_r;
  assign degenerate = degen_r;

  assign uv_nxt = nums.un + nums.vn;

  // With a negative denominator the inequalities flip instead of negating
  // all three values: U <= 0, V <= 0 and U + V > D.
  always_comb begin
    if (dzero_r) begin
      inside_nxt = 1'b0;
    end else if (!dneg_r) begin
      inside_nxt = !uneg_r && !vneg_r && (uv_r < den_r);
    end else begin
      inside_nxt = (uneg_r || uzero_r) && (vneg_r || vzero_r) && (uv_r > den_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      uv_r    <= uv_nxt;
      den_r   <= nums.den;
      dzero_r <= (nums.den == '0);
      dneg_r  <= nums.den[NW-1];
      uneg_r  <= nums.un[NW-1];
      uzero_r <= (nums.un == '0);
      vneg_r  <= nums.vn[NW-1];
      vzero_r <= (nums.vn == '0);
    end
    if (en[1]) begin
      inside_r <= inside_nxt;
      degen_r  <= dzero_r;
    end
  end

endmodule

`default_nettype wire

// ----- sv/point_in_triangle_test.sv -----
// Eight register stages lie between an input transfer and its result on out_tvalid.
// Throughput: one point per cycle unless the output stalls; every stage has its own
// valid bit and takes a new item whenever it is empty or its content moves on.
// A stalled output holds only the stages that are full behind it.
// Reset (synchronous, rst_n low) empties the pipeline and clears all vertex registers.
`default_nettype none

module point_in_triangle_test
  import pit_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Query points. in_tdata fields from bit 0: point_x, point_y, point_z.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // Results. out_tdata fields from bit 0: inside_res, then zero padding.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // out_tuser fields from bit 0: degenerate.
  output logic [0:0]                  out_tuser,
  // Vertex registers: vertex_a at 0x00, vertex_b at 0x08, vertex_c at 0x10.
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_AW-1:0]      cfg_paddr,
  input  wire logic [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]           cfg_prdata,
  output logic                        cfg_pready
);

  // The vertex registers. Each holds x, y and z as signed coordinates,
  // x in the low bits. Writes to the address past vertex_c are dropped.
  logic [3*CW-1:0] vert_a_r;
  logic [3*CW-1:0] vert_b_r;
  logic [3*CW-1:0] vert_c_r;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  verts_t               verts;

  logic  dot_valid, dot_ready;
  dots_t dots;
  logic  cross_valid, cross_ready;
  nums_t nums;
  logic  inside_res, degenerate;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_AW-1:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vert_a_r <= '0;
      vert_b_r <= '0;
      vert_c_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_VERTEX_A: vert_a_r <= cfg_pwdata[3*CW-1:0];
        REG_VERTEX_B: vert_b_r <= cfg_pwdata[3*CW-1:0];
        REG_VERTEX_C: vert_c_r <= cfg_pwdata[3*CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_VERTEX_A: cfg_prdata = CFG_DW'(vert_a_r);
      REG_VERTEX_B: cfg_prdata = CFG_DW'(vert_b_r);
      REG_VERTEX_C: cfg_prdata = CFG_DW'(vert_c_r);
      default:      cfg_prdata = '0;
    endcase
  end

  assign verts.a = vert_a_r;
  assign verts.b = vert_b_r;
  assign verts.c = vert_c_r;

  // Stages 1 to 3: edge vectors e0 = C - A and e1 = B - A, offset w = P - A,
  // coordinate products, then the five dot products.
  pit_dot u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .verts     (verts),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .point     (in_tdata[3*CW-1:0]),
    .out_valid (dot_valid),
    .out_ready (dot_ready),
    .dots      (dots)
  );

  // Stages 4 to 6: the six wide products, each built from two half-width
  // partial products, then D = d00*d11 - d01^2, U = d11*d02 - d01*d12 and
  // V = d00*d12 - d01*d02. All of it is exact.
  pit_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dot_valid),
    .in_ready  (dot_ready),
    .dots      (dots),
    .out_valid (cross_valid),
    .out_ready (cross_ready),
    .nums      (nums)
  );

  // Stages 7 and 8: the point is inside when u >= 0, v >= 0 and u + v < 1,
  // tested without division against the sign of D. A zero D marks a
  // degenerate triangle and always reads as outside.
  pit_decide u_decide (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (cross_valid),
    .in_ready   (cross_ready),
    .nums       (nums),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .inside_res (inside_res),
    .degenerate (degenerate)
  );

  assign out_tdata    = OUT_TDATA_W'(inside_res);
  assign out_tuser[0] = degenerate;

`ifndef SYNTHESIS
  // A degenerate triangle never reports a point inside.
  a_degen_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tdata[0])
    else $error("degenerate result reported inside");

  // With the output register empty, every stage can move, so input is taken.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output register");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

// ----- verif/pit_verdict_checker.sv -----
// Checker for the point-in-triangle block: tracks vertex register writes, predicts the
// inside and degenerate verdict of every accepted point and compares each result transfer.
// Depends on pit_pkg for widths and register indexes.
module pit_verdict_checker
  import pit_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [0:0]             out_tuser,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  input  logic                   cfg_pready,
  output int                     mismatches,
  output int                     pending_verdicts,
  output int                     results_seen,
  output int                     inside_seen,
  output int                     degenerate_seen
);

  typedef struct packed {
    logic in_tri;
    logic degenerate;
  } verdict_t;

  logic [3*CW-1:0] vert_a, vert_b, vert_c;
  verdict_t        expected_verdicts[$];

  initial begin
    mismatches       = 0;
    pending_verdicts = 0;
    results_seen     = 0;
    inside_seen      = 0;
    degenerate_seen  = 0;
  end

  function automatic longint coord_of(logic [3*CW-1:0] packed_xyz, int k);
    return longint'($signed(packed_xyz[CW*k +: CW]));
  endfunction

  // Exact barycentric test without division. All dot products fit in 64 bits and
  // their products in 128 bits, so no step can round or wrap.
  function automatic verdict_t judge_point(logic [3*CW-1:0] a, logic [3*CW-1:0] b,
                                           logic [3*CW-1:0] c, logic [3*CW-1:0] p);
    longint e0, e1, w, base;
    longint d00, d01, d02, d11, d12;
    logic signed [127:0] x00, x01, x02, x11, x12;
    logic signed [127:0] den, un, vn;
    verdict_t v;
    int k;
    d00 = 0; d01 = 0; d02 = 0; d11 = 0; d12 = 0;
    for (k = 0; k < 3; k++) begin
      base = coord_of(a, k);
      e0   = coord_of(c, k) - base;
      e1   = coord_of(b, k) - base;
      w    = coord_of(p, k) - base;
      d00 += e0 * e0;
      d01 += e0 * e1;
      d02 += e0 * w;
      d11 += e1 * e1;
      d12 += e1 * w;
    end
    x00 = d00; x01 = d01; x02 = d02; x11 = d11; x12 = d12;
    den = x00 * x11 - x01 * x01;
    un  = x11 * x02 - x01 * x12;
    vn  = x00 * x12 - x01 * x02;
    if (den == 0) begin
      v.in_tri     = 1'b0;
      v.degenerate = 1'b1;
    end else begin
      // Flip all three together so the comparisons can assume a positive denominator.
      if (den < 0) begin
        den = -den;
        un  = -un;
        vn  = -vn;
      end
      v.in_tri     = (un >= 0) && (vn >= 0) && ((un + vn) < den);
      v.degenerate = 1'b0;
    end
    return v;
  endfunction

  task automatic log_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t: %s, got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      vert_a <= '0;
      vert_b <= '0;
      vert_c <= '0;
      expected_verdicts.delete();
      pending_verdicts = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_AW-1:3])
          REG_VERTEX_A: vert_a <= cfg_pwdata[3*CW-1:0];
          REG_VERTEX_B: vert_b <= cfg_pwdata[3*CW-1:0];
          REG_VERTEX_C: vert_c <= cfg_pwdata[3*CW-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_verdicts.push_back(judge_point(vert_a, vert_b, vert_c, in_tdata[3*CW-1:0]));
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_verdicts.size() == 0) begin
          log_mismatch("result transfer with no point outstanding", out_tdata[0], 0);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_tdata[0] !== want.in_tri)
            log_mismatch("inside_res", out_tdata[0], want.in_tri);
          if (out_tuser[0] !== want.degenerate)
            log_mismatch("degenerate", out_tuser[0], want.degenerate);
          if (want.in_tri)
            inside_seen++;
          if (want.degenerate)
            degenerate_seen++;
        end
      end
      pending_verdicts = expected_verdicts.size();
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// Top of the point-in-triangle testbench: clock, reset, vertex programming over the
// register port and point stimulus under changing handshake pressure.
// Depends on pit_pkg, point_in_triangle_test and pit_verdict_checker.
module tb_top;
  import pit_pkg::*;

  // The index past the last vertex register; writes there must have no effect.
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int PHASE_POINTS = 155;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  // Fields from bit 0: point_x, point_y, point_z.
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  // Fields from bit 0: inside_res, then zero padding.
  logic [OUT_TDATA_W-1:0] out_tdata;
  // Fields from bit 0: degenerate.
  logic [0:0]             out_tuser;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr   = '0;
  logic [CFG_DW-1:0]      cfg_pwdata  = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  int mismatches, pending_verdicts, results_seen, inside_seen, degenerate_seen;

  // Percent of cycles in which the point source or the result sink idles.
  int send_idle = 0;
  int recv_idle = 0;
  // Long result stall: requested by the stimulus, timed by its own process.
  logic pressure_req = 1'b0;
  logic hold_off     = 1'b0;
  int   points_sent  = 0;
  int   settings_run = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  point_in_triangle_test dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  pit_verdict_checker checker_i (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .mismatches, .pending_verdicts, .results_seen, .inside_seen, .degenerate_seen
  );

  // The result sink accepts at random unless a long stall is in progress.
  always @(posedge clk) begin
    if (hold_off)
      out_tready <= 1'b0;
    else
      out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Once requested, the sink refuses results while hold_off is set. The pipeline fills up
  // behind it and in_tready has to fall while the source keeps offering points.
  initial begin
    wait (pressure_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #3200000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [3*CW-1:0] pack_vertex(int x, int y, int z);
    return {CW'(z), CW'(y), CW'(x)};
  endfunction

  function automatic int coord_at(logic [3*CW-1:0] v, int k);
    return int'($signed(v[CW*k +: CW]));
  endfunction

  function automatic int clamp_coord(int c);
    if (c > 32767)
      return 32767;
    if (c < -32768)
      return -32768;
    return c;
  endfunction

  // Most points are affine combinations of the vertices with weights a little past
  // the triangle on every side, so both verdicts stay frequent; some land exactly on
  // a vertex or an edge midpoint, and the rest are uniform over the whole range.
  function automatic logic [3*CW-1:0] pick_point(logic [3*CW-1:0] va, logic [3*CW-1:0] vb,
                                                 logic [3*CW-1:0] vc);
    int choice, n, wb, wc, k, jitter;
    int c[3];
    choice = $urandom_range(99);
    if (choice < 55) begin
      n      = $urandom_range(1, 32);
      wb     = int'($urandom_range(0, n + 8)) - 4;
      wc     = int'($urandom_range(0, n + 8)) - 4;
      jitter = ($urandom_range(99) < 30) ? 8 : 0;
      for (k = 0; k < 3; k++)
        c[k] = clamp_coord(coord_at(va, k)
                           + ((coord_at(vb, k) - coord_at(va, k)) * wb
                              + (coord_at(vc, k) - coord_at(va, k)) * wc) / n
                           + int'($urandom_range(0, 2 * jitter)) - jitter);
      return pack_vertex(c[0], c[1], c[2]);
    end else if (choice < 70) begin
      for (k = 0; k < 3; k++) begin
        case ($urandom_range(5))
          0: c[k] = coord_at(va, k);
          1: c[k] = coord_at(vb, k);
          2: c[k] = coord_at(vc, k);
          3: c[k] = (coord_at(va, k) + coord_at(vb, k)) >>> 1;
          4: c[k] = (coord_at(vb, k) + coord_at(vc, k)) >>> 1;
          default: c[k] = (coord_at(va, k) + coord_at(vc, k)) >>> 1;
        endcase
      end
      // Mixing sources per coordinate would scatter the point; keep one source in most picks.
      if ($urandom_range(99) < 80) begin
        case ($urandom_range(5))
          0: return va;
          1: return vb;
          2: return vc;
          3: return pack_vertex((coord_at(va, 0) + coord_at(vb, 0)) >>> 1,
                                (coord_at(va, 1) + coord_at(vb, 1)) >>> 1,
                                (coord_at(va, 2) + coord_at(vb, 2)) >>> 1);
          4: return pack_vertex((coord_at(vb, 0) + coord_at(vc, 0)) >>> 1,
                                (coord_at(vb, 1) + coord_at(vc, 1)) >>> 1,
                                (coord_at(vb, 2) + coord_at(vc, 2)) >>> 1);
          default: return pack_vertex((coord_at(va, 0) + coord_at(vc, 0)) >>> 1,
                                      (coord_at(va, 1) + coord_at(vc, 1)) >>> 1,
                                      (coord_at(va, 2) + coord_at(vc, 2)) >>> 1);
        endcase
      end
      return pack_vertex(c[0], c[1], c[2]);
    end
    return (3*CW)'({$urandom, $urandom});
  endfunction

  // Register write: setup cycle, access cycle until pready, then the bus idles again.
  // Bits above the 48 vertex bits carry random junk that the block must drop.
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [3*CW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= {(CFG_DW - 3*CW)'($urandom), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (!cfg_pready);
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every point has produced its result, plus the pipeline depth, so a
  // register write can never overtake a point still in flight.
  task automatic wait_idle();
    do @(negedge clk); while (pending_verdicts != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic load_triangle(logic [3*CW-1:0] va, logic [3*CW-1:0] vb,
                               logic [3*CW-1:0] vc, bit poke_spare);
    wait_idle();
    if (poke_spare)
      write_reg(REG_SPARE, (3*CW)'({$urandom, $urandom}));
    write_reg(REG_VERTEX_A, va);
    write_reg(REG_VERTEX_B, vb);
    write_reg(REG_VERTEX_C, vc);
    settings_run++;
  endtask

  // Called at a rising edge; returns at the edge where the transfer happened.
  task automatic send_point(logic [3*CW-1:0] p);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    points_sent++;
  endtask

  task automatic run_points(logic [3*CW-1:0] va, logic [3*CW-1:0] vb,
                            logic [3*CW-1:0] vc, int count);
    int i;
    for (i = 0; i < count; i++)
      send_point(pick_point(va, vb, vc));
    in_tvalid <= 1'b0;
  endtask

  initial begin
    logic [3*CW-1:0] va, vb, vc, d;
    int ph, k, waited;
    int c[3];

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Right after reset all vertices sit at the origin, so every
    // point, including the field extremes, must come back degenerate.
    send_idle = 0;
    recv_idle <= 0;
    send_point(pack_vertex(-32768, -32768, -32768));
    send_point(pack_vertex(32767, 32767, 32767));
    send_point(pack_vertex(0, 0, 0));
    send_point(pack_vertex(-32768, 32767, -1));
    in_tvalid <= 1'b0;

    // A triangle spanning the full range with even coordinates, so the midpoint of
    // the edge from B to C is exact. Points on edges through A count as inside, points
    // on the far edge, B and C too, do not. A spare register write must change nothing.
    va = pack_vertex(-32768, -32768, 0);
    vb = pack_vertex(32766, -32768, 0);
    vc = pack_vertex(-32768, 32766, 0);
    load_triangle(va, vb, vc, 1'b1);
    send_point(va);
    send_point(vb);
    send_point(vc);
    send_point(pack_vertex(-1, -32768, 0));
    send_point(pack_vertex(-32768, -1, 0));
    send_point(pack_vertex(-1, -1, 0));
    send_point(pack_vertex(-2, -2, 0));
    send_point(pack_vertex(0, 0, 0));
    send_point(pack_vertex(-10923, -10923, 0));
    send_point(pack_vertex(-30000, -30000, 32767));
    send_point(pack_vertex(-30000, -30000, -32768));
    send_point(pack_vertex(32767, 32767, 0));
    send_point(pack_vertex(-32768, -32768, -32768));
    send_point(pack_vertex(32767, -32768, 32767));
    send_point(pack_vertex(-32768, 32767, 32767));
    in_tvalid <= 1'b0;

    // Random part: twelve vertex settings. The kind cycles through full random,
    // small, corner-of-range and degenerate triangles; the handshake pattern changes
    // every four settings.
    for (ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin
          va = (3*CW)'({$urandom, $urandom});
          vb = (3*CW)'({$urandom, $urandom});
          vc = (3*CW)'({$urandom, $urandom});
        end
        1: begin
          for (k = 0; k < 3; k++)
            c[k] = int'($urandom_range(0, 128)) - 64;
          va = pack_vertex(c[0], c[1], c[2]);
          for (k = 0; k < 3; k++)
            c[k] = int'($urandom_range(0, 128)) - 64;
          vb = pack_vertex(c[0], c[1], c[2]);
          for (k = 0; k < 3; k++)
            c[k] = int'($urandom_range(0, 128)) - 64;
          vc = pack_vertex(c[0], c[1], c[2]);
        end
        2: begin
          for (k = 0; k < 9; k++) begin
            case ($urandom_range(3))
              0: c[k % 3] = -32768;
              1: c[k % 3] = 32767;
              2: c[k % 3] = 0;
              default: c[k % 3] = -1;
            endcase
            if (k == 2)
              va = pack_vertex(c[0], c[1], c[2]);
            else if (k == 5)
              vb = pack_vertex(c[0], c[1], c[2]);
            else if (k == 8)
              vc = pack_vertex(c[0], c[1], c[2]);
          end
        end
        default: begin
          // Degenerate triangles: collinear, then two coincident vertices, then all three.
          for (k = 0; k < 3; k++)
            c[k] = int'($urandom_range(0, 2000)) - 1000;
          va = pack_vertex(c[0], c[1], c[2]);
          d  = pack_vertex(int'($urandom_range(0, 100)) - 50,
                           int'($urandom_range(0, 100)) - 50,
                           int'($urandom_range(0, 100)) - 50);
          vb = pack_vertex(c[0] + 3 * coord_at(d, 0), c[1] + 3 * coord_at(d, 1),
                           c[2] + 3 * coord_at(d, 2));
          vc = pack_vertex(c[0] - 5 * coord_at(d, 0), c[1] - 5 * coord_at(d, 1),
                           c[2] - 5 * coord_at(d, 2));
          if (ph == 7)
            vc = vb;
          else if (ph == 11) begin
            vb = va;
            vc = va;
          end
        end
      endcase
      load_triangle(va, vb, vc, (ph % 3) == 0);

      if (ph < 4) begin
        send_idle = 9;
        recv_idle <= 62;
      end else if (ph < 8) begin
        send_idle = 62;
        recv_idle <= 9;
      end else begin
        send_idle = 0;
        recv_idle <= 0;
      end
      if (ph == 8)
        pressure_req <= 1'b1;
      run_points(va, vb, vc, PHASE_POINTS);
    end

    // Drain: wait for the last results with a bound, then the pipeline depth.
    waited = 0;
    while (pending_verdicts != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d points across %0d vertex settings, idling each side in turn.",
             points_sent, settings_run);
    $display("Checked %0d results: %0d inside, %0d degenerate.",
             results_seen, inside_seen, degenerate_seen);
    if (mismatches == 0 && pending_verdicts == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- point_in_triangle_test.f -----
sv/pit_pkg.sv
sv/pit_dot.sv
sv/pit_cross.sv
sv/pit_decide.sv
sv/point_in_triangle_test.sv
verif/pit_verdict_checker.sv
verif/tb_top.sv
